// ----- rtl/kmst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_pkg: shared types and microprogram for the spanning-forest edge filter
// Holds field widths, the sequencer step and control word types, and the
// read-only control store that drives the union-find datapath.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int DEF_MAX_VERTICES = 64;

    localparam int END_W       = 6;
    localparam int WEIGHT_W    = 32;
    localparam int COUNT_W     = 6;
    localparam int RANK_W      = 3;
    localparam int VCOUNT_W    = 7;

    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = 2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [COUNT_W-1:0]  TREE_MAX     = 6'd63;
    localparam logic [RANK_W-1:0]   RANK_MAX     = 3'd7;

    // Sequencer steps, one per control store entry.
    typedef enum logic [3:0] {
        ST_FETCH,
        ST_CHECK,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_COMP_CHK,
        ST_COMP_WR,
        ST_SIDE_END,
        ST_JOIN,
        ST_BUMP,
        ST_EMIT
    } step_t;

    // Datapath operation of one step.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_FETCH,
        OP_FOLLOW,
        OP_COMPRESS,
        OP_NEXT_SIDE,
        OP_JOIN,
        OP_BUMP,
        OP_EMIT
    } op_t;

    // Jump condition of one step: hit takes hit_step, miss takes miss_step.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_BAD,
        C_ROOT,
        C_AT_ROOT,
        C_SIDE_A,
        C_SAME,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t hit_step;
        step_t miss_step;
    } ucode_t;

    // The microprogram. Each endpoint gets a root search that follows
    // parent links, then a second walk that points the path at the root.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            ST_FETCH:    w = '{OP_FETCH,     C_ACCEPT,   ST_CHECK,    ST_FETCH};
            ST_CHECK:    w = '{OP_NONE,      C_BAD,      ST_EMIT,     ST_FIND_RD};
            ST_FIND_RD:  w = '{OP_NONE,      C_ALWAYS,   ST_FIND_CHK, ST_FIND_CHK};
            ST_FIND_CHK: w = '{OP_FOLLOW,    C_ROOT,     ST_COMP_CHK, ST_FIND_RD};
            ST_COMP_CHK: w = '{OP_NONE,      C_AT_ROOT,  ST_SIDE_END, ST_COMP_WR};
            ST_COMP_WR:  w = '{OP_COMPRESS,  C_ALWAYS,   ST_COMP_CHK, ST_COMP_CHK};
            ST_SIDE_END: w = '{OP_NEXT_SIDE, C_SIDE_A,   ST_FIND_RD,  ST_JOIN};
            ST_JOIN:     w = '{OP_JOIN,      C_SAME,     ST_EMIT,     ST_BUMP};
            ST_BUMP:     w = '{OP_BUMP,      C_ALWAYS,   ST_EMIT,     ST_EMIT};
            ST_EMIT:     w = '{OP_EMIT,      C_OUT_FREE, ST_FETCH,    ST_EMIT};
            default:     w = '{OP_NONE,      C_ALWAYS,   ST_FETCH,    ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/kruskal_mst_edge_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_mst_edge_filter: union-find edge filter for spanning forests
// Microcoded sequencer over one node memory that decides, edge by edge,
// whether an edge joins the spanning forest of a weight-sorted edge stream.
// ----------------------------------------------------------------------------
// Usage:
// Edges enter on the s_ channel one word at a time, already sorted by weight.
// s_tuser[0] marks the first edge of a graph; it empties the forest and the
// tree edge count before that edge is handled. Each edge gives one result
// word on the m_ channel that echoes the edge, flags it as accepted or as
// having a bad endpoint, and carries the running tree edge count.
// The cfg_ channel writes the vertex count; write it only while no edge is
// in flight. A new count keeps the forest; only a first edge empties it.
// An edge with a bad endpoint skips the root searches. Otherwise each
// endpoint is walked to its root and its path is compressed: every hop is
// a registered read of the node memory, and every compressed node is a read
// followed by a write. An accepted edge also takes the rank update step.
// The result sits in an output register; the next edge is taken while it
// waits. If the receiver stalls with a result still pending, the sequencer
// holds at its last step until the register frees up.
// After reset the forest is empty (every vertex its own root, by per-entry
// valid bits), the count is zero and the vertex count is 64.
// ----------------------------------------------------------------------------
module kruskal_mst_edge_filter #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kmst_pkg::VCOUNT_W-1:0]   cfg_data,   // vertex_count

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] end_a, [11:6] end_b, [43:12] edge_weight, [47:44] zero
    input  logic [kmst_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] first_edge
    input  logic [kmst_pkg::S_TUSER_W-1:0]  s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] out_a, [11:6] out_b, [43:12] out_weight, [49:44] tree_edges,
    // [55:50] zero
    output logic [kmst_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] accepted, [1] bad_vertex
    output logic [kmst_pkg::M_TUSER_W-1:0]  m_tuser
);
    import kmst_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = VW + RANK_W;
    localparam int EXT_W = VW + END_W;
    localparam int PAD_W = M_TDATA_W - (2 * END_W + WEIGHT_W + COUNT_W);

    // Sequencer.
    step_t                  upc_reg, upc_next;
    ucode_t                 uword;
    logic                   cond_hit;

    // Configuration.
    logic [VCOUNT_W-1:0]    vcount_reg;

    // Edge registers.
    logic [END_W-1:0]       end_a_reg, end_b_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                   bad_reg, acc_reg;
    logic [COUNT_W-1:0]     tree_count_reg;

    // Union-find datapath.
    logic [VW-1:0]          a_idx, b_idx;
    logic [EXT_W-1:0]       a_ext, b_ext;
    logic [VW-1:0]          cur_reg;
    logic                   side_reg;
    logic [VW-1:0]          root_a_reg, root_b_reg;
    logic [RANK_W-1:0]      rank_a_reg, rank_b_reg;
    logic [VW-1:0]          side_root;

    // Node memory: {rank, parent} per vertex, plus one valid flop each.
    logic [NW-1:0]          node_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [NW-1:0]          rd_word_reg;
    logic                   rd_valid_reg;
    logic [VW-1:0]          eff_parent;
    logic [RANK_W-1:0]      eff_rank;
    logic                   mem_we;
    logic [VW-1:0]          mem_addr;
    logic [NW-1:0]          mem_wdata;

    // Output register.
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;
    logic                   out_free;

    logic                   in_fire;
    logic                   in_bad;
    logic                   clear_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = (upc_reg == ST_FETCH);
    assign in_fire   = s_tvalid && s_tready;
    assign clear_fire = in_fire && s_tuser[0];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An endpoint is bad at or above the vertex count, which is capped at
    // the memory depth.
    assign in_bad = (32'(s_tdata[END_W-1:0]) >= 32'(vcount_reg))
                 || (32'(s_tdata[END_W-1:0]) >= 32'(MAX_VERTICES))
                 || (32'(s_tdata[2*END_W-1:END_W]) >= 32'(vcount_reg))
                 || (32'(s_tdata[2*END_W-1:END_W]) >= 32'(MAX_VERTICES));

    // Endpoint to memory index; only used when the endpoint is in range.
    assign a_ext = EXT_W'(end_a_reg);
    assign b_ext = EXT_W'(end_b_reg);
    assign a_idx = a_ext[VW-1:0];
    assign b_idx = b_ext[VW-1:0];

    // An entry never written since the last clear is its own root, rank 0.
    assign eff_parent = rd_valid_reg ? rd_word_reg[VW-1:0] : cur_reg;
    assign eff_rank   = rd_valid_reg ? rd_word_reg[NW-1:VW] : '0;
    assign side_root  = side_reg ? root_b_reg : root_a_reg;

    // Control store lookup and jump decision.
    always_comb begin
        uword = ucode_rom(upc_reg);
        case (uword.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_ACCEPT:   cond_hit = in_fire;
            C_BAD:      cond_hit = bad_reg;
            C_ROOT:     cond_hit = (eff_parent == cur_reg);
            C_AT_ROOT:  cond_hit = (cur_reg == side_root);
            C_SIDE_A:   cond_hit = !side_reg;
            C_SAME:     cond_hit = (root_a_reg == root_b_reg);
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b1;
        endcase
        upc_next = cond_hit ? uword.hit_step : uword.miss_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // Memory write port: path compression and the two halves of a union.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = cur_reg;
        mem_wdata = {RANK_W'(0), side_root};
        case (uword.op)
            OP_COMPRESS: begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg;
                mem_wdata = {RANK_W'(0), side_root};
            end
            OP_JOIN: begin
                mem_we = (root_a_reg != root_b_reg);
                if (rank_a_reg < rank_b_reg) begin
                    mem_addr  = root_a_reg;
                    mem_wdata = {rank_a_reg, root_b_reg};
                end else begin
                    mem_addr  = root_b_reg;
                    mem_wdata = {rank_b_reg, root_a_reg};
                end
            end
            OP_BUMP: begin
                mem_we    = (rank_a_reg == rank_b_reg) && (rank_a_reg != RANK_MAX);
                mem_addr  = root_a_reg;
                mem_wdata = {rank_a_reg + RANK_W'(1), root_a_reg};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_addr] <= mem_wdata;
        end
        rd_word_reg <= node_mem[cur_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[cur_reg];
            if (clear_fire) begin
                valid_reg <= '0;
            end else if (mem_we) begin
                valid_reg[mem_addr] <= 1'b1;
            end
        end
    end

    // Control state: configuration, tree count, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg     <= VCOUNT_RESET;
            tree_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
            end
            if (clear_fire) begin
                tree_count_reg <= '0;
            end else if (uword.op == OP_JOIN && root_a_reg != root_b_reg
                         && tree_count_reg != TREE_MAX) begin
                tree_count_reg <= tree_count_reg + COUNT_W'(1);
            end
            if (uword.op == OP_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (uword.op)
            OP_FETCH: begin
                if (in_fire) begin
                    end_a_reg  <= s_tdata[END_W-1:0];
                    end_b_reg  <= s_tdata[2*END_W-1:END_W];
                    weight_reg <= s_tdata[2*END_W+WEIGHT_W-1:2*END_W];
                    bad_reg    <= in_bad;
                    acc_reg    <= 1'b0;
                    side_reg   <= 1'b0;
                end
            end
            OP_FOLLOW: begin
                if (eff_parent == cur_reg) begin
                    if (side_reg) begin
                        root_b_reg <= cur_reg;
                        rank_b_reg <= eff_rank;
                        cur_reg    <= b_idx;
                    end else begin
                        root_a_reg <= cur_reg;
                        rank_a_reg <= eff_rank;
                        cur_reg    <= a_idx;
                    end
                end else begin
                    cur_reg <= eff_parent;
                end
            end
            OP_COMPRESS: begin
                cur_reg <= eff_parent;
            end
            OP_NEXT_SIDE: begin
                if (!side_reg) begin
                    side_reg <= 1'b1;
                    cur_reg  <= b_idx;
                end
            end
            OP_JOIN: begin
                acc_reg <= (root_a_reg != root_b_reg);
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {PAD_W'(0), tree_count_reg, weight_reg,
                                    end_b_reg, end_a_reg};
                    m_tuser_reg <= {bad_reg, acc_reg};
                end
            end
            default: begin
            end
        endcase
        // The root search of side A starts from end_a, loaded in the check step
        // after fetch since the index comes from the captured endpoint.
        if (uword.op == OP_NONE && upc_reg == ST_CHECK) begin
            cur_reg <= a_idx;
        end
    end

`ifndef SYNTHESIS
    // A first edge empties the tree count.
    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_fire |=> tree_count_reg == '0)
        else $error("tree count not cleared by first edge");

    // Between clears the tree count never goes down.
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(clear_fire)
        |-> tree_count_reg >= $past(tree_count_reg))
        else $error("tree count went down without a clear");

    // An edge is never both accepted and bad.
    a_acc_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tuser_reg[0] && m_tuser_reg[1]))
        else $error("result both accepted and bad");

    // An accepted edge always shows at least one tree edge.
    a_acc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0]
        |-> m_tdata_reg[2*END_W+WEIGHT_W+COUNT_W-1:2*END_W+WEIGHT_W] != '0)
        else $error("accepted edge with zero tree count");

    // Memory is never written while an edge is being fetched.
    a_no_fetch_write: assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg == ST_FETCH |-> !mem_we)
        else $error("node memory written during fetch");
`endif

endmodule
